// ===== rtl/core/sv32_page_table_walker_defines.svh =====
// ----------------------------------------------------------------------------
// Sv32 page table walker: assertion macros
// Shared concurrent assertion forms used by the walker's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef SV32_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV32_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SV32PTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SV32PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sv32ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// Sv32 page table walker package
// Types, field widths and codes shared by the walker's modules.
// ----------------------------------------------------------------------------
package sv32ptw_pkg;

    localparam int unsigned VA_W   = 32;
    localparam int unsigned PPN_W  = 22;
    localparam int unsigned PTE_W  = 32;
    localparam int unsigned PA_W   = 34;
    localparam int unsigned VPN_W  = 10;
    localparam int unsigned OFFS_W = 12;
    // Only VPN[0] and the page offset are needed once the walk has started.
    localparam int unsigned HELD_W = VPN_W + OFFS_W;

    // Command codes of an input beat.
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_RESPONSE  = 1'b1;

    // Kind codes of a result beat.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Walk status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_RESERVED   = 3'd2,
        ST_LAST_PTR   = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_MEM_ERR    = 3'd5
    } t_status;

    // One input beat.
    typedef struct packed {
        logic              cmd;
        logic [VA_W-1:0]   virt_addr;
        logic [PPN_W-1:0]  root_page;
        logic [PTE_W-1:0]  entry_word;
        logic              mem_fail;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic             kind;
        logic [PA_W-1:0]  read_addr;
        logic [PA_W-1:0]  phys_addr;
        t_status          status;
    } t_rsp;

    // Walk context carried between beats.
    typedef struct packed {
        logic              walking;
        logic              level;
        logic [HELD_W-1:0] held_va;
    } t_walk_state;

endpackage

// ===== rtl/core/sv32ptw_if.sv =====
// ----------------------------------------------------------------------------
// Sv32 page table walker channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------

// Request channel: translate requests and page table entry responses.
interface sv32ptw_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] virt_addr;
    logic [21:0] root_page;
    logic [31:0] entry_word;
    logic        mem_fail;

    modport source (
        output valid, cmd, virt_addr, root_page, entry_word, mem_fail,
        input  ready
    );
    modport sink (
        input  valid, cmd, virt_addr, root_page, entry_word, mem_fail,
        output ready
    );
endinterface

// Result channel: entry read requests and finished translations.
interface sv32ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [33:0] read_addr;
    logic [33:0] phys_addr;
    logic [2:0]  status;

    modport source (
        output valid, kind, read_addr, phys_addr, status,
        input  ready
    );
    modport sink (
        input  valid, kind, read_addr, phys_addr, status,
        output ready
    );
endinterface

// ===== rtl/core/sv32ptw_step.sv =====
// ----------------------------------------------------------------------------
// Sv32 page table walker step logic
// Decodes one beat against the walk context and forms the result beat
// and the next walk context.
// ----------------------------------------------------------------------------
module sv32ptw_step (
    input  sv32ptw_pkg::t_req        i_req,
    input  sv32ptw_pkg::t_walk_state i_state,
    output logic                     o_has_rsp,
    output sv32ptw_pkg::t_rsp        o_rsp,
    output sv32ptw_pkg::t_walk_state o_state
);
    import sv32ptw_pkg::*;

    logic              w_v;
    logic              w_r;
    logic              w_w;
    logic              w_x;
    logic [PPN_W-1:0]  w_ppn;
    logic [VPN_W-1:0]  w_ppn0;
    logic [11:0]       w_ppn1;
    logic [VPN_W-1:0]  w_vpn1;
    logic [VPN_W-1:0]  w_held_vpn0;
    logic [OFFS_W-1:0] w_held_offs;

    // Entry and address fields.
    assign w_v         = i_req.entry_word[0];
    assign w_r         = i_req.entry_word[1];
    assign w_w         = i_req.entry_word[2];
    assign w_x         = i_req.entry_word[3];
    assign w_ppn       = i_req.entry_word[31:10];
    assign w_ppn0      = w_ppn[9:0];
    assign w_ppn1      = w_ppn[21:10];
    assign w_vpn1      = i_req.virt_addr[31:22];
    assign w_held_vpn0 = i_state.held_va[HELD_W-1:OFFS_W];
    assign w_held_offs = i_state.held_va[OFFS_W-1:0];

    // Walk step: start, descend or finish.
    always_comb begin
        o_has_rsp       = 1'b0;
        o_rsp.kind      = KIND_READ;
        o_rsp.read_addr = '0;
        o_rsp.phys_addr = '0;
        o_rsp.status    = ST_OK;
        o_state         = i_state;

        if (i_req.cmd == CMD_TRANSLATE) begin
            // A new request drops any walk in progress.
            o_has_rsp       = 1'b1;
            o_rsp.read_addr = {i_req.root_page, w_vpn1, 2'b00};
            o_state.walking = 1'b1;
            o_state.level   = 1'b1;
            o_state.held_va = i_req.virt_addr[HELD_W-1:0];
        end else if (i_state.walking) begin
            o_has_rsp       = 1'b1;
            o_rsp.kind      = KIND_DONE;
            o_state.walking = 1'b0;
            o_state.level   = 1'b1;
            if (i_req.mem_fail) begin
                o_rsp.status = ST_MEM_ERR;
            end else if (!w_v) begin
                o_rsp.status = ST_INVALID;
            end else if (!w_r && w_w) begin
                o_rsp.status = ST_RESERVED;
            end else if (w_r || w_x) begin
                // Leaf entry; a superpage passes VPN[0] through.
                if (i_state.level) begin
                    if (w_ppn0 != '0) begin
                        o_rsp.status = ST_MISALIGNED;
                    end else begin
                        o_rsp.phys_addr = {w_ppn1, w_held_vpn0, w_held_offs};
                    end
                end else begin
                    o_rsp.phys_addr = {w_ppn, w_held_offs};
                end
            end else if (!i_state.level) begin
                o_rsp.status = ST_LAST_PTR;
            end else begin
                // Pointer at the first level: read the second-level entry.
                o_rsp.kind      = KIND_READ;
                o_rsp.read_addr = {w_ppn, w_held_vpn0, 2'b00};
                o_state.walking = 1'b1;
                o_state.level   = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/sv32_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// Sv32 page table walker
// Two-level translation: emits entry read addresses and finishes with a
// physical address or a fault status.
// ----------------------------------------------------------------------------
//
//  Port     Dir  Beat carries
//  -------  ---  ---------------------------------------------------------
//  i_req    in   cmd, virt_addr, root_page, entry_word, mem_fail
//  o_rsp    out  kind, read_addr, phys_addr, status
//
//  Each beat is captured in the input register and decoded through the single
//  decode stage into the result register; throughput is one beat per cycle
//  while the result channel does not stall.
//  A response that arrives while idle is dropped without a result beat.
//  A stalled result beat holds the result register; the input register still
//  drains beats that make no result. Reset is synchronous and clears the
//  valid flags and the walk context.
//
module sv32_page_table_walker (
    input logic          i_clk,
    input logic          i_rst_n,
    sv32ptw_req_if.sink   i_req,
    sv32ptw_rsp_if.source o_rsp
);
    import sv32ptw_pkg::*;

`include "sv32_page_table_walker_defines.svh"

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;
    t_walk_state r_state;
    t_walk_state n_state;
    t_req        w_req;
    t_rsp        w_rsp;
    logic        w_has_rsp;
    logic        w_out_free;
    logic        w_adv;

    // Flow control between the two registers.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_adv       = r_in_valid && (!w_has_rsp || w_out_free);
    assign i_req.ready = !r_in_valid || w_adv;

    // Gather the request payload.
    assign w_req.cmd        = i_req.cmd;
    assign w_req.virt_addr  = i_req.virt_addr;
    assign w_req.root_page  = i_req.root_page;
    assign w_req.entry_word = i_req.entry_word;
    assign w_req.mem_fail   = i_req.mem_fail;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= w_req;
        end
    end

    // Decode of the registered beat.
    sv32ptw_step u_step (
        .i_req     (r_in),
        .i_state   (r_state),
        .o_has_rsp (w_has_rsp),
        .o_rsp     (w_rsp),
        .o_state   (n_state)
    );

    // Walk context advances with each decoded beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.walking <= 1'b0;
            r_state.level   <= 1'b1;
            r_state.held_va <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_has_rsp) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has_rsp) begin
            r_out <= w_rsp;
        end
    end

    // Drive the result channel.
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.kind      = r_out.kind;
    assign o_rsp.read_addr = r_out.read_addr;
    assign o_rsp.phys_addr = r_out.phys_addr;
    assign o_rsp.status    = r_out.status;

    // Checks on the walk context and the result register.
    `SV32PTW_ASSERT_NEXT(a_start_walk, i_clk, i_rst_n,
        w_adv && (r_in.cmd == CMD_TRANSLATE), r_state.walking && r_state.level,
        "translate request did not start a first-level walk")
    `SV32PTW_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n,
        w_adv && w_has_rsp && (w_rsp.kind == KIND_DONE), !r_state.walking && r_state.level,
        "finished translation left the walker busy")
    `SV32PTW_ASSERT_NOW(a_read_ok, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == KIND_READ), (r_out.status == ST_OK) && (r_out.phys_addr == '0),
        "read request beat carries a status or address")
    `SV32PTW_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.status != ST_OK), r_out.phys_addr == '0,
        "faulted translation carries a physical address")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv32 page table walker testbench
// Sends translate requests and page table entry responses into the walker.
// A behavioral predictor works out each result beat, and a checker compares
// the beats in order. Both channels idle at random, and there is one long
// result stall that backs the walker up.
// ----------------------------------------------------------------------------
module testbench;
    import sv32ptw_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_BEATS   = 700;
    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    // Shapes of entry response that the stimulus can ask for.
    typedef enum int {
        PTE_POINTER,
        PTE_LEAF,
        PTE_SUPER,
        PTE_MISALIGNED,
        PTE_INVALID,
        PTE_RESERVED,
        PTE_MEM_FAIL
    } t_pte_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sv32ptw_req_if req_ch();
    sv32ptw_rsp_if rsp_ch();

    sv32_page_table_walker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted walk context and the result beats still due.
    logic        pt_walking = 1'b0;
    logic        pt_level   = 1'b1;
    logic [31:0] pt_vaddr   = '0;
    t_rsp        walk_results_due[$];

    // Idling controls and the long result stall, counted down by the receiver.
    bit src_gaps_on       = 1'b0;
    bit snk_gaps_on       = 1'b0;
    int stall_hold_left   = 0;
    int sink_wait         = 0;

    int beats_accepted  = 0;
    int ignored_beats   = 0;
    int results_checked = 0;
    int faults_checked  = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Unused fields of a beat carry random values so that their being ignored is checked.
    function automatic t_req translate_beat(logic [31:0] va, logic [21:0] root);
        t_req b;
        b            = '0;
        b.cmd        = CMD_TRANSLATE;
        b.virt_addr  = va;
        b.root_page  = root;
        b.entry_word = $urandom;
        b.mem_fail   = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic t_req response_beat(logic [31:0] word, logic fail);
        t_req b;
        b            = '0;
        b.cmd        = CMD_RESPONSE;
        b.virt_addr  = $urandom;
        b.root_page  = 22'($urandom);
        b.entry_word = word;
        b.mem_fail   = fail;
        return b;
    endfunction

    // Random entry word forced into the requested shape.
    function automatic t_req shaped_response(t_pte_shape s);
        logic [31:0] w;
        w = $urandom;
        case (s)
            PTE_POINTER: begin
                w[3:0] = 4'b0001;
            end
            PTE_INVALID: begin
                w[0] = 1'b0;
            end
            PTE_RESERVED: begin
                w[2:0] = 3'b101;
            end
            PTE_MEM_FAIL: begin
            end
            default: begin
                // A leaf: valid, readable or executable, and never write-only.
                w[0] = 1'b1;
                if (!w[1] && !w[3]) w[3] = 1'b1;
                if (!w[1]) w[2] = 1'b0;
                if (s == PTE_SUPER) w[19:10] = '0;
                if (s == PTE_MISALIGNED && w[19:10] == '0) w[10 + $urandom_range(0, 9)] = 1'b1;
            end
        endcase
        return response_beat(w, s == PTE_MEM_FAIL);
    endfunction

    // Advance the predicted walk by one accepted beat and queue its result.
    task automatic walk_step(input t_req b);
        t_rsp        r;
        logic [21:0] ppn;
        logic [9:0]  vpn0;
        r        = '0;
        r.status = ST_OK;
        ppn      = b.entry_word[31:10];
        vpn0     = pt_vaddr[21:12];
        if (b.cmd == CMD_TRANSLATE) begin
            // A new request always restarts at the root table.
            pt_vaddr   = b.virt_addr;
            pt_level   = 1'b1;
            pt_walking = 1'b1;
            r.kind     = KIND_READ;
            r.read_addr = {b.root_page, 12'h000} + {22'd0, b.virt_addr[31:22], 2'b00};
            walk_results_due.push_back(r);
        end else if (!pt_walking) begin
            ignored_beats++;
        end else begin
            // Memory, invalid and reserved faults are checked in priority order before the leaf test.
            r.kind = KIND_DONE;
            if (b.mem_fail) begin
                r.status = ST_MEM_ERR;
            end else if (!b.entry_word[0]) begin
                r.status = ST_INVALID;
            end else if (!b.entry_word[1] && b.entry_word[2]) begin
                r.status = ST_RESERVED;
            end else if (b.entry_word[1] || b.entry_word[3]) begin
                if (!pt_level) begin
                    r.phys_addr = {ppn, pt_vaddr[11:0]};
                end else if (ppn[9:0] != '0) begin
                    r.status = ST_MISALIGNED;
                end else begin
                    r.phys_addr = {ppn[21:10], pt_vaddr[21:0]};
                end
            end else if (!pt_level) begin
                r.status = ST_LAST_PTR;
            end else begin
                // Pointer at the top level: fetch the second-level entry.
                r.kind      = KIND_READ;
                r.read_addr = {ppn, 12'h000} + {22'd0, vpn0, 2'b00};
                pt_level    = 1'b0;
            end
            if (r.kind == KIND_DONE) begin
                pt_walking = 1'b0;
                pt_level   = 1'b1;
            end
            walk_results_due.push_back(r);
        end
    endtask

    // Offer one beat, wait for it to be taken, then predict its result.
    task automatic send_beat(input t_req b);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= b.cmd;
        req_ch.virt_addr  <= b.virt_addr;
        req_ch.root_page  <= b.root_page;
        req_ch.entry_word <= b.entry_word;
        req_ch.mem_fail   <= b.mem_fail;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        beats_accepted++;
        walk_step(b);
        @(negedge i_clk);
    endtask

    // Stop offering beats and let every predicted result come out.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (walk_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One walk with random content; the noisy form adds stray and broken beats.
    task automatic run_walk(input bit noisy);
        int         pick;
        t_pte_shape shape;
        if (noisy && $urandom_range(0, 99) < 8) begin
            send_beat(response_beat($urandom, 1'($urandom_range(0, 1))));
        end
        send_beat(translate_beat($urandom, 22'($urandom)));
        if (noisy && $urandom_range(0, 99) < 5) begin
            send_beat(translate_beat($urandom, 22'($urandom)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)      shape = PTE_POINTER;
        else if (pick < 65) shape = PTE_SUPER;
        else if (pick < 72) shape = PTE_MISALIGNED;
        else if (pick < 80) shape = PTE_INVALID;
        else if (pick < 86) shape = PTE_RESERVED;
        else if (pick < 92) shape = PTE_MEM_FAIL;
        else                shape = PTE_LEAF;
        send_beat(shaped_response(shape));
        // Second level, unless a noisy walk is left hanging.
        if (shape == PTE_POINTER && !(noisy && $urandom_range(0, 99) < 5)) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      shape = PTE_LEAF;
            else if (pick < 65) shape = PTE_POINTER;
            else if (pick < 75) shape = PTE_INVALID;
            else if (pick < 85) shape = PTE_RESERVED;
            else if (pick < 92) shape = PTE_MEM_FAIL;
            else                shape = PTE_MISALIGNED;
            send_beat(shaped_response(shape));
        end
    endtask

    // Edge values of every field and each fault in turn.
    task automatic test_directed();
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        // A response with no walk running makes no result.
        send_beat(response_beat(32'h0000_000F, 1'b0));
        // Lowest address and root, then a pointer to the top page and a leaf with every flag.
        send_beat(translate_beat(32'h0000_0000, 22'h000000));
        send_beat(response_beat(32'hFFFF_FC01, 1'b0));
        send_beat(response_beat(32'hFFFF_FFFF, 1'b0));
        // Highest address and root with an aligned superpage.
        send_beat(translate_beat(32'hFFFF_FFFF, 22'h3FFFFF));
        send_beat(response_beat(32'hFFF0_03FF, 1'b0));
        // Superpage whose low page number is not zero.
        send_beat(translate_beat(32'h1234_5678, 22'h15555A));
        send_beat(response_beat(32'h0000_0403, 1'b0));
        // Every bit set except valid.
        send_beat(translate_beat(32'hAAAA_AAAA, 22'h2AAAAA));
        send_beat(response_beat(32'hFFFF_FFFE, 1'b0));
        // A memory error wins over a good leaf.
        send_beat(translate_beat(32'h5555_5555, 22'h155555));
        send_beat(response_beat(32'h0000_000B, 1'b1));
        // Writable but not readable is reserved.
        send_beat(translate_beat(32'h8000_1000, 22'h000001));
        send_beat(response_beat(32'h0000_0005, 1'b0));
        // Pointer at the last level.
        send_beat(translate_beat(32'h0040_2FFC, 22'h200000));
        send_beat(response_beat(32'h0000_0401, 1'b0));
        send_beat(response_beat(32'h0000_0801, 1'b0));
        // A new request drops the walk in progress.
        send_beat(translate_beat(32'h0000_0123, 22'h000010));
        send_beat(translate_beat(32'hFFC0_0ABC, 22'h000020));
        send_beat(response_beat(32'h0000_000B, 1'b0));
        // Execute-only leaf at the second level.
        send_beat(translate_beat(32'h7FFF_F001, 22'h0ABCDE));
        send_beat(response_beat(32'h0012_3401, 1'b0));
        send_beat(response_beat(32'hABCD_E009, 1'b0));
        // Stray response once the walk has finished.
        send_beat(response_beat(32'h0000_0001, 1'b1));
        wait_drained();
    endtask

    // Mostly well-formed walks with random content, idling switched now and then.
    task automatic test_random_walks();
        int start_count;
        int walks;
        start_count = beats_accepted - ignored_beats;
        walks       = 0;
        while (beats_accepted - ignored_beats - start_count < RANDOM_BEATS) begin
            if (walks % 40 == 0) begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                snk_gaps_on = ($urandom_range(0, 3) != 0);
            end
            run_walk(1'b1);
            walks++;
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_result_stall();
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b1;
        @(posedge i_clk);
        stall_hold_left = STALL_CYCLES;
        @(negedge i_clk);
        for (int i = 0; i < 12; i++) begin
            run_walk(1'b0);
        end
        wait_drained();
    endtask

    // Receiver: long hold-off first, then random stalls when enabled.
    always @(negedge i_clk) begin
        if (stall_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_hold_left = stall_hold_left - 1;
        end else if (sink_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            sink_wait = sink_wait - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (snk_gaps_on) sink_wait = pick_gap();
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (walk_results_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d status %0d",
                       rsp_ch.kind, rsp_ch.status);
                mismatch_count++;
            end else begin
                want = walk_results_due.pop_front();
                results_checked++;
                if (want.kind == KIND_DONE && want.status != ST_OK) faults_checked++;
                if (rsp_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
                    mismatch_count++;
                end
                if (rsp_ch.read_addr !== want.read_addr) begin
                    $error("read_addr: expected %h, actual %h", want.read_addr, rsp_ch.read_addr);
                    mismatch_count++;
                end
                if (rsp_ch.phys_addr !== want.phys_addr) begin
                    $error("phys_addr: expected %h, actual %h", want.phys_addr, rsp_ch.phys_addr);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat moving on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, walk_results_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_TRANSLATE;
        req_ch.virt_addr  = '0;
        req_ch.root_page  = '0;
        req_ch.entry_word = '0;
        req_ch.mem_fail   = 1'b0;
        rsp_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_walks();
        test_result_stall();

        $display("walker run: %0d beats accepted, %0d of them stray responses, %0d results checked",
                 beats_accepted, ignored_beats, results_checked);
        $display("walks ending in a fault: %0d; one result stall of %0d cycles",
                 faults_checked, STALL_CYCLES);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
